>>> rtl/core/fir_pkg.sv
// shared types and constants of the loadable-tap fir filter
`default_nettype none

package fir_pkg;

    localparam int MAX_TAPS_DEF    = 64;
    localparam int DATA_W          = 16;
    localparam int TAP_COUNT_W     = 7;
    localparam int TAP_INDEX_W     = 6;
    localparam int TAP_COUNT_RESET = 64;
    localparam int PROD_W          = 2 * DATA_W;
    localparam int FRAC_BITS       = 15;

    typedef enum logic [0:0] {
        OP_FILTER = 1'b0,
        OP_LOAD   = 1'b1
    } fir_op_t;

    typedef struct packed {
        fir_op_t                  op;
        logic [TAP_INDEX_W-1:0]   tap_index;
        logic signed [DATA_W-1:0] coefficient;
        logic signed [DATA_W-1:0] sample;
    } fir_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered;
        logic                     saturated;
    } fir_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } fir_state_t;

    typedef struct packed {
        logic acc_clear;
        logic issue;
    } fir_mac_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/fir_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/fir_mac.sv
// shared multiply-accumulate unit with round and saturate of the sum
`default_nettype none

module fir_mac #(
    parameter int MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire fir_pkg::fir_mac_ctrl_t           ctrl,
    input  wire logic signed [fir_pkg::DATA_W-1:0] coef_rd,
    input  wire logic signed [fir_pkg::DATA_W-1:0] hist_rd,
    output logic                                  busy,
    output fir_pkg::fir_out_t                     result
);

    localparam int ACC_W = fir_pkg::PROD_W + $clog2(MAX_TAPS);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (fir_pkg::FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] OUT_MAX    = ACC_W'((1 << (fir_pkg::DATA_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN    = ACC_W'(-(1 << (fir_pkg::DATA_W - 1)));

    logic                              rd_valid_reg;
    logic                              prod_valid_reg;
    logic signed [fir_pkg::PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           rounded;
    logic signed [ACC_W-1:0]           shifted;

    // ram read data lines up with the registered issue flag rd_valid_reg
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= ctrl.issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= fir_pkg::PROD_W'(coef_rd) * fir_pkg::PROD_W'(hist_rd);
        if (ctrl.acc_clear) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy = rd_valid_reg | prod_valid_reg;

    // round half up, then clip to the output range
    always_comb begin
        rounded = acc_reg + ROUND_HALF;
        shifted = rounded >>> fir_pkg::FRAC_BITS;
        if (shifted > OUT_MAX) begin
            result.filtered  = fir_pkg::DATA_W'(OUT_MAX);
            result.saturated = 1'b1;
        end else if (shifted < OUT_MIN) begin
            result.filtered  = fir_pkg::DATA_W'(OUT_MIN);
            result.saturated = 1'b1;
        end else begin
            result.filtered  = fir_pkg::DATA_W'(shifted);
            result.saturated = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fir_filter_loadable_taps_unit.sv
// Direct-form fir filter with a loadable coefficient store.
// Input channel s_*: one item per transfer. A load item (op = load) writes
// a coefficient at tap_index and gives no result; s_ready stays high for
// the next item. A filter item gives one result on m_*: the sum of
// coefficient j times the sample j+1 filter items back, j below tap_count,
// rounded half up by 15 bits and clipped to 16 bits with a saturated flag.
// The new sample then enters the history.
// A filter item runs one multiply-accumulate per tap through a single
// multiplier (tap_count above MAX_TAPS counts as MAX_TAPS): the issue state
// reads the taps in turn, the drain state waits for the last product to
// reach the accumulator and the finish state puts the result in the output
// register; with tap_count zero the item goes straight to the finish state.
// s_ready is low while an item is worked.
// The result sits in an output register: the next item is taken while it
// waits, and a filter item finishing before the receiver has taken the
// previous result holds until m_ready.
// cfg_*: writes tap_count, always ready; write only while the block is idle.
// After reset a clearing pass over every address zeroes the history and
// the coefficients; s_ready stays low meanwhile. tap_count resets to 64.
`default_nettype none

module fir_filter_loadable_taps_unit #(
    parameter int MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire fir_pkg::fir_in_t                    s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output fir_pkg::fir_out_t                        m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fir_pkg::TAP_COUNT_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    fir_pkg::fir_state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] hist_addr_reg, hist_addr_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [TW-1:0] taps_reg, taps_next;
    logic [TW-1:0] taps_in;
    logic signed [fir_pkg::DATA_W-1:0] sample_reg, sample_next;
    logic [fir_pkg::TAP_COUNT_W-1:0] tap_count_reg;
    logic m_valid_reg, m_valid_next;
    fir_pkg::fir_out_t m_data_reg, m_data_next;

    logic                         coef_we;
    logic [AW-1:0]                coef_waddr;
    logic [fir_pkg::DATA_W-1:0]   coef_wdata;
    logic [fir_pkg::DATA_W-1:0]   coef_rdata;
    logic                         hist_we;
    logic [AW-1:0]                hist_waddr;
    logic [fir_pkg::DATA_W-1:0]   hist_wdata;
    logic [fir_pkg::DATA_W-1:0]   hist_rdata;

    fir_pkg::fir_mac_ctrl_t mac_ctrl;
    logic                   mac_busy;
    fir_pkg::fir_out_t      mac_result;

    fir_ram #(
        .WIDTH (fir_pkg::DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (cnt_reg),
        .rdata (coef_rdata)
    );

    fir_ram #(
        .WIDTH (fir_pkg::DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_addr_reg),
        .rdata (hist_rdata)
    );

    fir_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .coef_rd (coef_rdata),
        .hist_rd (hist_rdata),
        .busy    (mac_busy),
        .result  (mac_result)
    );

    // tap count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= fir_pkg::TAP_COUNT_W'(fir_pkg::TAP_COUNT_RESET);
        end else if (cfg_valid && cfg_ready) begin
            tap_count_reg <= cfg_data;
        end
    end

    // tap count clipped to the store depth
    always_comb begin
        if (32'(tap_count_reg) > MAX_TAPS) begin
            taps_in = TW'(MAX_TAPS);
        end else begin
            taps_in = TW'(tap_count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fir_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            ptr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            ptr_reg      <= ptr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        hist_addr_reg <= hist_addr_next;
        taps_reg      <= taps_next;
        sample_reg    <= sample_next;
        m_data_reg    <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cnt_next       = cnt_reg;
        hist_addr_next = hist_addr_reg;
        ptr_next       = ptr_reg;
        taps_next      = taps_reg;
        sample_next    = sample_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        s_ready            = 1'b0;
        mac_ctrl.acc_clear = 1'b0;
        mac_ctrl.issue     = 1'b0;
        coef_we            = 1'b0;
        coef_waddr         = AW'(s_data.tap_index);
        coef_wdata         = s_data.coefficient;
        hist_we            = 1'b0;
        hist_waddr         = ptr_reg;
        hist_wdata         = sample_reg;

        unique case (state_reg)
            fir_pkg::ST_CLEAR: begin
                coef_we    = 1'b1;
                coef_waddr = clr_addr_reg;
                coef_wdata = '0;
                hist_we    = 1'b1;
                hist_waddr = clr_addr_reg;
                hist_wdata = '0;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = fir_pkg::ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            fir_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.op == fir_pkg::OP_LOAD) begin
                        // load of an index beyond the store is dropped
                        coef_we = (32'(s_data.tap_index) < MAX_TAPS);
                    end else begin
                        sample_next        = s_data.sample;
                        taps_next          = taps_in;
                        cnt_next           = '0;
                        hist_addr_next     = (ptr_reg == '0) ? LAST_ADDR : ptr_reg - AW'(1);
                        mac_ctrl.acc_clear = 1'b1;
                        state_next         = (taps_in == '0) ? fir_pkg::ST_FINISH
                                                             : fir_pkg::ST_ISSUE;
                    end
                end
            end
            fir_pkg::ST_ISSUE: begin
                mac_ctrl.issue = 1'b1;
                cnt_next       = cnt_reg + AW'(1);
                hist_addr_next = (hist_addr_reg == '0) ? LAST_ADDR
                                                       : hist_addr_reg - AW'(1);
                if ((TW'(cnt_reg) + TW'(1)) == taps_reg) begin
                    state_next = fir_pkg::ST_DRAIN;
                end
            end
            fir_pkg::ST_DRAIN: begin
                // wait for the last product to reach the accumulator
                if (!mac_busy) begin
                    state_next = fir_pkg::ST_FINISH;
                end
            end
            fir_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = mac_result;
                    hist_we      = 1'b1;
                    ptr_next     = (ptr_reg == LAST_ADDR) ? '0 : ptr_reg + AW'(1);
                    state_next   = fir_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fir_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
